@@ rtl/checked_int32_alu_defines.svh @@
// Assertion macros shared by the checker files.
`ifndef CHECKED_INT32_ALU_DEFINES_SVH
`define CHECKED_INT32_ALU_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define CIA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define CIA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/cia_pkg.sv @@
// Package with the opcodes, status codes and item types of the checked ALU.
`default_nettype none
package cia_pkg;
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_REM = 3'd4;
  localparam logic [2:0] OP_EQ  = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  // Bounds of the signed 32-bit result range.
  localparam logic signed [31:0] RANGE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] RANGE_MIN = 32'sh8000_0000;

  // Unit class chosen by the front end.
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ADD  = 2'd1,
    KIND_MUL  = 2'd2,
    KIND_DIV  = 2'd3
  } kind_e;

  // Classified item passed from the front end to the back end.
  typedef struct packed {
    kind_e              kind;
    logic               sub;
    logic               rem;
    logic               div0;
    logic               eq;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } cmd_t;

  // Result item.
  typedef struct packed {
    logic               eq;
    logic [1:0]         status;
    logic signed [31:0] result;
  } res_t;
endpackage
`default_nettype wire

@@ rtl/cia_front.sv @@
// Front end: accepts input items, decodes the opcode and spots zero divisors.
`default_nettype none
module cia_front (
  input  wire  logic             clk_i,
  input  wire  logic             rst_ni,
  input  wire  logic             in_valid_i,
  output logic                   in_ready_o,
  input  wire  logic [2:0]       opcode_i,
  input  wire  logic signed [31:0] a_i,
  input  wire  logic signed [31:0] b_i,
  output logic                   cmd_valid_o,
  input  wire  logic             cmd_ready_i,
  output cia_pkg::cmd_t          cmd_o
);
  import cia_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  // Decode the opcode into a unit class and flags.
  always_comb begin
    cmd_d      = '0;
    cmd_d.a    = a_i;
    cmd_d.b    = b_i;
    cmd_d.kind = KIND_NONE;
    unique case (opcode_i)
      OP_ADD: cmd_d.kind = KIND_ADD;
      OP_SUB: begin
        cmd_d.kind = KIND_ADD;
        cmd_d.sub  = 1'b1;
      end
      OP_MUL: cmd_d.kind = KIND_MUL;
      OP_DIV, OP_REM: begin
        cmd_d.kind = KIND_DIV;
        cmd_d.rem  = (opcode_i == OP_REM);
        cmd_d.div0 = (b_i == 32'sd0);
      end
      OP_EQ: cmd_d.eq = (a_i == b_i);
      default: cmd_d.kind = KIND_NONE;
    endcase
  end

  assign valid_d = in_ready_o ? in_valid_i : valid_q;

  // Pipeline register toward the queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q <= cmd_d;
    end
  end
endmodule
`default_nettype wire

@@ rtl/cia_queue.sv @@
// Short queue between the front end and the back end.
`default_nettype none
module cia_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire  logic   clk_i,
  input  wire  logic   rst_ni,
  input  wire  logic   wr_valid_i,
  output logic         wr_ready_o,
  input  wire  cia_pkg::cmd_t wr_data_i,
  output logic         rd_valid_o,
  input  wire  logic   rd_ready_i,
  output cia_pkg::cmd_t rd_data_o
);
  import cia_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic wr_en, rd_en;

  assign wr_ready_o = (cnt_q != (PtrW+1)'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rptr_q];
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;

  // Pointer and fill count update with wrap at the depth.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (wr_en) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (rd_en) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    cnt_d = cnt_q + (PtrW+1)'(wr_en) - (PtrW+1)'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end
endmodule
`default_nettype wire

@@ rtl/cia_back.sv @@
// Back end: pipelined add, multiply and radix-2 divide with range checks.
`default_nettype none
module cia_back (
  input  wire  logic   clk_i,
  input  wire  logic   rst_ni,
  input  wire  logic   cmd_valid_i,
  output logic         cmd_ready_o,
  input  wire  cia_pkg::cmd_t cmd_i,
  output logic         res_valid_o,
  input  wire  logic   res_ready_i,
  output cia_pkg::res_t res_o
);
  import cia_pkg::*;

  // Stage count: one entry stage, 32 divide steps, one finish stage.
  localparam int unsigned NSt = 34;

  typedef struct packed {
    kind_e       kind;
    logic        rem;
    logic        div0;
    logic        eq;
    logic        neg_q;
    logic        neg_r;
    logic [31:0] quo;
    logic [32:0] rmd;
    logic [31:0] dvs;
    logic signed [63:0] wide;
  } stg_t;

  stg_t st_q [NSt];
  stg_t st_d [NSt];
  logic [NSt-1:0] v_q;
  logic adv;
  logic out_v_q;
  res_t out_q, out_d;
  logic [31:0] mag_a, mag_b;

  // The whole pipe moves together; the output register frees it.
  assign adv         = !out_v_q || res_ready_i;
  assign cmd_ready_o = adv;
  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

  assign mag_a = cmd_i.a[31] ? 32'(-cmd_i.a) : cmd_i.a;
  assign mag_b = cmd_i.b[31] ? 32'(-cmd_i.b) : cmd_i.b;

  // Entry stage: add, subtract and multiply at 64 bits, and operand magnitudes.
  always_comb begin
    st_d[0]       = '0;
    st_d[0].kind  = cmd_i.kind;
    st_d[0].rem   = cmd_i.rem;
    st_d[0].div0  = cmd_i.div0;
    st_d[0].eq    = cmd_i.eq;
    st_d[0].neg_q = cmd_i.a[31] ^ cmd_i.b[31];
    st_d[0].neg_r = cmd_i.a[31];
    st_d[0].quo   = mag_a;
    st_d[0].dvs   = mag_b;
    case (cmd_i.kind)
      KIND_ADD: st_d[0].wide = cmd_i.sub ? (64'(cmd_i.a) - 64'(cmd_i.b))
                                         : (64'(cmd_i.a) + 64'(cmd_i.b));
      KIND_MUL: st_d[0].wide = 64'(cmd_i.a) * 64'(cmd_i.b);
      default:  st_d[0].wide = '0;
    endcase
  end

  // One restoring divide step per stage.
  for (genvar s = 1; s <= 32; s++) begin : g_div
    logic [32:0] sh;
    logic [32:0] df;
    always_comb begin
      st_d[s] = st_q[s-1];
      sh      = {st_q[s-1].rmd[31:0], st_q[s-1].quo[31]};
      df      = sh - {1'b0, st_q[s-1].dvs};
      if (!df[32]) begin
        st_d[s].rmd = df;
        st_d[s].quo = {st_q[s-1].quo[30:0], 1'b1};
      end else begin
        st_d[s].rmd = sh;
        st_d[s].quo = {st_q[s-1].quo[30:0], 1'b0};
      end
    end
  end

  // Last pipe stage: signed quotient or remainder at 64 bits.
  always_comb begin
    st_d[NSt-1] = st_q[NSt-2];
    if (st_q[NSt-2].kind == KIND_DIV) begin
      if (st_q[NSt-2].rem) begin
        st_d[NSt-1].wide = st_q[NSt-2].neg_r ? -64'(st_q[NSt-2].rmd[31:0])
                                             : 64'(st_q[NSt-2].rmd[31:0]);
      end else begin
        st_d[NSt-1].wide = st_q[NSt-2].neg_q ? -64'(st_q[NSt-2].quo)
                                             : 64'(st_q[NSt-2].quo);
      end
    end
  end

  // Range check and status in front of the output register.
  always_comb begin
    out_d = '0;
    unique case (st_q[NSt-1].kind)
      KIND_NONE: out_d.eq = st_q[NSt-1].eq;
      KIND_ADD, KIND_MUL, KIND_DIV: begin
        if (st_q[NSt-1].div0 && st_q[NSt-1].kind == KIND_DIV) begin
          out_d.status = ST_DIV0;
        end else if (st_q[NSt-1].wide > 64'(RANGE_MAX)
                     || st_q[NSt-1].wide < 64'(RANGE_MIN)) begin
          out_d.status = ST_OVF;
        end else begin
          out_d.result = st_q[NSt-1].wide[31:0];
        end
      end
      default: out_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v_q     <= {v_q[NSt-2:0], cmd_valid_i};
      out_v_q <= v_q[NSt-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NSt; i++) begin
        st_q[i] <= st_d[i];
      end
      out_q <= out_d;
    end
  end
endmodule
`default_nettype wire

@@ rtl/checked_int32_alu.sv @@
// Top level of the checked signed 32-bit ALU.
// Usage: the slave channel s_axis_* takes one item per handshake; tdata holds
// opcode (3 bits), operand_a (32) and operand_b (32) from bit 0 up. The
// master channel m_axis_* returns one item for each input item, in order;
// tdata holds result (32), status (2) and equal (1) from bit 0 up.
// From the input handshake an item passes through the front end register,
// the queue, 34 back end stages (32 of them the radix-2 divide steps) and
// the output register before its result is valid.
// Throughput is one item per cycle for every opcode while the receiver does
// not stall, because the divider is fully pipelined.
// Reset clears all valid flags and the queue; no item is in flight after it.
// When the receiver stalls, the back end pipe holds, the queue fills and
// s_axis_tready falls once the queue and front register are full.
`default_nettype none
module checked_int32_alu #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        s_axis_tvalid,
  output logic              s_axis_tready,
  // opcode [2:0], operand_a [34:3], operand_b [66:35], zero fill [71:67]
  input  wire  logic [71:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire  logic        m_axis_tready,
  // result [31:0], status [33:32], equal [34], zero fill [39:35]
  output logic [39:0]       m_axis_tdata
);
  import cia_pkg::*;

  logic f_valid, f_ready, b_valid, b_ready;
  cmd_t f_cmd, b_cmd;
  res_t res;

  cia_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .opcode_i   (s_axis_tdata[2:0]),
    .a_i        (s_axis_tdata[34:3]),
    .b_i        (s_axis_tdata[66:35]),
    .cmd_valid_o(f_valid),
    .cmd_ready_i(f_ready),
    .cmd_o      (f_cmd)
  );

  cia_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid),
    .wr_ready_o(f_ready),
    .wr_data_i (f_cmd),
    .rd_valid_o(b_valid),
    .rd_ready_i(b_ready),
    .rd_data_o (b_cmd)
  );

  cia_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(b_valid),
    .cmd_ready_o(b_ready),
    .cmd_i      (b_cmd),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {5'd0, res.eq, res.status, res.result};
endmodule
`default_nettype wire

@@ rtl/cia_checker.sv @@
// Port checker for the checked ALU and its bind statement.
`default_nettype none
`include "checked_int32_alu_defines.svh"
module cia_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);
  import cia_pkg::*;

  `CIA_ASSERT_IMP(a_stat_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[33:32] != 2'd3, "status code out of range")
  `CIA_ASSERT_IMP(a_zero_on_err, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[33:32] != ST_OK, m_axis_tdata[31:0] == 32'd0, "result not zero on error")
  `CIA_ASSERT_IMP(a_eq_clean, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[34], m_axis_tdata[33:0] == 34'd0, "equal set with data")
  `CIA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `CIA_ASSERT_NEXT(a_quiet, clk_i, rst_ni, !$past(rst_ni), !m_axis_tvalid, "result right after reset")
endmodule

bind checked_int32_alu cia_checker u_cia_checker (
  .clk_i, .rst_ni,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire
